[rtl/core/riscv_instruction_encoder_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the instruction encoder
// Shared clocking and reset qualification for the encoder's port checks.
// ----------------------------------------------------------------------------
`ifndef RISCV_INSTRUCTION_ENCODER_CORE_ASSERT_SVH
`define RISCV_INSTRUCTION_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RVIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RVIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rvie_pkg.sv]
// ----------------------------------------------------------------------------
// Instruction encoder package
// Action codes, format kinds, opcodes and the field packing functions.
// ----------------------------------------------------------------------------
package rvie_pkg;

    localparam logic [6:0] OPC_OP      = 7'h33;
    localparam logic [6:0] OPC_OPIMM   = 7'h13;
    localparam logic [6:0] OPC_LOAD    = 7'h03;
    localparam logic [6:0] OPC_STORE   = 7'h23;
    localparam logic [6:0] OPC_LUI     = 7'h37;
    localparam logic [6:0] OPC_AUIPC   = 7'h17;
    localparam logic [6:0] OPC_BRANCH  = 7'h63;
    localparam logic [6:0] OPC_JAL     = 7'h6F;
    localparam logic [6:0] OPC_JALR    = 7'h67;
    localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
    localparam logic [6:0] OPC_OP32    = 7'h3B;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;

    localparam logic signed [31:0] IMM12_MIN  = -32'sd2048;
    localparam logic signed [31:0] IMM12_MAX  = 32'sd2047;
    localparam logic signed [31:0] BR_MIN     = -32'sd4096;
    localparam logic signed [31:0] BR_MAX     = 32'sd4094;
    localparam logic signed [31:0] JMP_MIN    = -32'sd1048576;
    localparam logic signed [31:0] JMP_MAX    = 32'sd1048574;

    typedef enum logic [5:0] {
        ACT_ADD   = 6'd0,  ACT_SUB   = 6'd1,  ACT_SLL   = 6'd2,  ACT_SLT   = 6'd3,
        ACT_SLTU  = 6'd4,  ACT_XOR   = 6'd5,  ACT_SRL   = 6'd6,  ACT_SRA   = 6'd7,
        ACT_OR    = 6'd8,  ACT_AND   = 6'd9,  ACT_MUL   = 6'd10, ACT_ADDI  = 6'd11,
        ACT_SLTI  = 6'd12, ACT_SLTIU = 6'd13, ACT_XORI  = 6'd14, ACT_ORI   = 6'd15,
        ACT_ANDI  = 6'd16, ACT_SLLI  = 6'd17, ACT_SRLI  = 6'd18, ACT_SRAI  = 6'd19,
        ACT_LB    = 6'd20, ACT_LH    = 6'd21, ACT_LW    = 6'd22, ACT_LBU   = 6'd23,
        ACT_LHU   = 6'd24, ACT_SB    = 6'd25, ACT_SH    = 6'd26, ACT_SW    = 6'd27,
        ACT_LUI   = 6'd28, ACT_AUIPC = 6'd29, ACT_BEQ   = 6'd30, ACT_BNE   = 6'd31,
        ACT_BLT   = 6'd32, ACT_BGE   = 6'd33, ACT_BLTU  = 6'd34, ACT_BGEU  = 6'd35,
        ACT_JAL   = 6'd36, ACT_JALR  = 6'd37, ACT_J     = 6'd38, ACT_CALL  = 6'd39,
        ACT_RET   = 6'd40, ACT_JR    = 6'd41, ACT_BEQZ  = 6'd42, ACT_BNEZ  = 6'd43,
        ACT_NOP   = 6'd44, ACT_MV    = 6'd45, ACT_LI    = 6'd46, ACT_LWU   = 6'd47,
        ACT_LD    = 6'd48, ACT_SD    = 6'd49, ACT_ADDIW = 6'd50, ACT_SLLIW = 6'd51,
        ACT_SRLIW = 6'd52, ACT_SRAIW = 6'd53, ACT_ADDW  = 6'd54, ACT_SUBW  = 6'd55,
        ACT_SLLW  = 6'd56, ACT_SRLW  = 6'd57, ACT_SRAW  = 6'd58
    } t_action;

    typedef enum logic [4:0] {
        KIND_R, KIND_I, KIND_SH, KIND_SHW, KIND_S, KIND_U, KIND_B, KIND_BZ,
        KIND_J, KIND_JZ, KIND_JRA, KIND_RET, KIND_JR, KIND_NOP, KIND_MV, KIND_LI,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
    } t_act;

    // Operand range checks, worked out in the first stage.
    typedef struct packed {
        logic fits12;
        logic le63;
        logic le31;
        logic even;
        logic br_ok;
        logic jmp_ok;
    } t_chk;

    function automatic t_act mk(t_kind k, logic [6:0] o, logic [2:0] f, logic [6:0] s);
        t_act a;
        a.kind = k;
        a.opc  = o;
        a.f3   = f;
        a.f7   = s;
        return a;
    endfunction

    function automatic t_act decode_action(logic [5:0] code);
        t_act a;
        unique case (code)
            ACT_ADD:   a = mk(KIND_R,   OPC_OP,      3'd0, 7'h00);
            ACT_SUB:   a = mk(KIND_R,   OPC_OP,      3'd0, 7'h20);
            ACT_SLL:   a = mk(KIND_R,   OPC_OP,      3'd1, 7'h00);
            ACT_SLT:   a = mk(KIND_R,   OPC_OP,      3'd2, 7'h00);
            ACT_SLTU:  a = mk(KIND_R,   OPC_OP,      3'd3, 7'h00);
            ACT_XOR:   a = mk(KIND_R,   OPC_OP,      3'd4, 7'h00);
            ACT_SRL:   a = mk(KIND_R,   OPC_OP,      3'd5, 7'h00);
            ACT_SRA:   a = mk(KIND_R,   OPC_OP,      3'd5, 7'h20);
            ACT_OR:    a = mk(KIND_R,   OPC_OP,      3'd6, 7'h00);
            ACT_AND:   a = mk(KIND_R,   OPC_OP,      3'd7, 7'h00);
            ACT_MUL:   a = mk(KIND_R,   OPC_OP,      3'd0, 7'h01);
            ACT_ADDI:  a = mk(KIND_I,   OPC_OPIMM,   3'd0, 7'h00);
            ACT_SLTI:  a = mk(KIND_I,   OPC_OPIMM,   3'd2, 7'h00);
            ACT_SLTIU: a = mk(KIND_I,   OPC_OPIMM,   3'd3, 7'h00);
            ACT_XORI:  a = mk(KIND_I,   OPC_OPIMM,   3'd4, 7'h00);
            ACT_ORI:   a = mk(KIND_I,   OPC_OPIMM,   3'd6, 7'h00);
            ACT_ANDI:  a = mk(KIND_I,   OPC_OPIMM,   3'd7, 7'h00);
            ACT_SLLI:  a = mk(KIND_SH,  OPC_OPIMM,   3'd1, 7'h00);
            ACT_SRLI:  a = mk(KIND_SH,  OPC_OPIMM,   3'd5, 7'h00);
            ACT_SRAI:  a = mk(KIND_SH,  OPC_OPIMM,   3'd5, 7'h10);
            ACT_LB:    a = mk(KIND_I,   OPC_LOAD,    3'd0, 7'h00);
            ACT_LH:    a = mk(KIND_I,   OPC_LOAD,    3'd1, 7'h00);
            ACT_LW:    a = mk(KIND_I,   OPC_LOAD,    3'd2, 7'h00);
            ACT_LBU:   a = mk(KIND_I,   OPC_LOAD,    3'd4, 7'h00);
            ACT_LHU:   a = mk(KIND_I,   OPC_LOAD,    3'd5, 7'h00);
            ACT_SB:    a = mk(KIND_S,   OPC_STORE,   3'd0, 7'h00);
            ACT_SH:    a = mk(KIND_S,   OPC_STORE,   3'd1, 7'h00);
            ACT_SW:    a = mk(KIND_S,   OPC_STORE,   3'd2, 7'h00);
            ACT_LUI:   a = mk(KIND_U,   OPC_LUI,     3'd0, 7'h00);
            ACT_AUIPC: a = mk(KIND_U,   OPC_AUIPC,   3'd0, 7'h00);
            ACT_BEQ:   a = mk(KIND_B,   OPC_BRANCH,  3'd0, 7'h00);
            ACT_BNE:   a = mk(KIND_B,   OPC_BRANCH,  3'd1, 7'h00);
            ACT_BLT:   a = mk(KIND_B,   OPC_BRANCH,  3'd4, 7'h00);
            ACT_BGE:   a = mk(KIND_B,   OPC_BRANCH,  3'd5, 7'h00);
            ACT_BLTU:  a = mk(KIND_B,   OPC_BRANCH,  3'd6, 7'h00);
            ACT_BGEU:  a = mk(KIND_B,   OPC_BRANCH,  3'd7, 7'h00);
            ACT_JAL:   a = mk(KIND_J,   OPC_JAL,     3'd0, 7'h00);
            ACT_JALR:  a = mk(KIND_I,   OPC_JALR,    3'd0, 7'h00);
            ACT_J:     a = mk(KIND_JZ,  OPC_JAL,     3'd0, 7'h00);
            ACT_CALL:  a = mk(KIND_JRA, OPC_JAL,     3'd0, 7'h00);
            ACT_RET:   a = mk(KIND_RET, OPC_JALR,    3'd0, 7'h00);
            ACT_JR:    a = mk(KIND_JR,  OPC_JALR,    3'd0, 7'h00);
            ACT_BEQZ:  a = mk(KIND_BZ,  OPC_BRANCH,  3'd0, 7'h00);
            ACT_BNEZ:  a = mk(KIND_BZ,  OPC_BRANCH,  3'd1, 7'h00);
            ACT_NOP:   a = mk(KIND_NOP, OPC_OPIMM,   3'd0, 7'h00);
            ACT_MV:    a = mk(KIND_MV,  OPC_OPIMM,   3'd0, 7'h00);
            ACT_LI:    a = mk(KIND_LI,  OPC_OPIMM,   3'd0, 7'h00);
            ACT_LWU:   a = mk(KIND_I,   OPC_LOAD,    3'd6, 7'h00);
            ACT_LD:    a = mk(KIND_I,   OPC_LOAD,    3'd3, 7'h00);
            ACT_SD:    a = mk(KIND_S,   OPC_STORE,   3'd3, 7'h00);
            ACT_ADDIW: a = mk(KIND_I,   OPC_OPIMM32, 3'd0, 7'h00);
            ACT_SLLIW: a = mk(KIND_SHW, OPC_OPIMM32, 3'd1, 7'h00);
            ACT_SRLIW: a = mk(KIND_SHW, OPC_OPIMM32, 3'd5, 7'h00);
            ACT_SRAIW: a = mk(KIND_SHW, OPC_OPIMM32, 3'd5, 7'h20);
            ACT_ADDW:  a = mk(KIND_R,   OPC_OP32,    3'd0, 7'h00);
            ACT_SUBW:  a = mk(KIND_R,   OPC_OP32,    3'd0, 7'h20);
            ACT_SLLW:  a = mk(KIND_R,   OPC_OP32,    3'd1, 7'h00);
            ACT_SRLW:  a = mk(KIND_R,   OPC_OP32,    3'd5, 7'h00);
            ACT_SRAW:  a = mk(KIND_R,   OPC_OP32,    3'd5, 7'h20);
            default:   a = mk(KIND_BAD, OPC_OP,      3'd0, 7'h00);
        endcase
        return a;
    endfunction

    function automatic logic [31:0] pack_r(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
                                           logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] pack_i(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                           logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] pack_s(logic [6:0] opc, logic [2:0] f3, logic [4:0] rs1,
                                           logic [4:0] rs2, logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
    endfunction

    function automatic logic [31:0] pack_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                           logic [12:0] off);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] pack_j(logic [4:0] rd, logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

endpackage

[rtl/core/riscv_instruction_encoder_core.sv]
// ----------------------------------------------------------------------------
// RISC-V RV32I/RV64I instruction encoder core
// Three register stages (decode and range check, field packing, output); a
// word passes through them in order; one request a cycle unless stalled.
// A long li holds the output stage two beats. Sync reset clears valid bits.
// ----------------------------------------------------------------------------
module riscv_instruction_encoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [5:0]          i_action,
    input  logic [4:0]          i_dest_reg,
    input  logic [4:0]          i_src1_reg,
    input  logic [4:0]          i_src2_reg,
    input  logic signed [31:0]  i_immediate_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_instruction_word,
    output logic                o_rejected,
    output logic                o_last_word
);

    // Stage 1: decoded action, registers and range flags.
    logic                r_s1_vld;
    rvie_pkg::t_act      r_s1_act;
    logic [4:0]          r_s1_rd;
    logic [4:0]          r_s1_rs1;
    logic [4:0]          r_s1_rs2;
    logic [31:0]         r_s1_imm;
    rvie_pkg::t_chk      r_s1_chk;
    rvie_pkg::t_chk      n_s1_chk;

    // Stage 2: packed words.
    logic                r_s2_vld;
    logic [31:0]         r_s2_word0;
    logic [31:0]         r_s2_word1;
    logic                r_s2_two;
    logic                r_s2_rej;
    logic [31:0]         n_s2_word0;
    logic [31:0]         n_s2_word1;
    logic                n_s2_two;
    logic                n_s2_rej;

    // Stage 3: output register.
    logic                r_s3_vld;
    logic [31:0]         r_s3_word;
    logic [31:0]         r_s3_word1;
    logic                r_s3_two;
    logic                r_s3_rej;

    logic                w_en1;
    logic                w_en2;
    logic                w_en3;
    logic                w_out_beat;
    logic [19:0]         w_li_hi;

    assign w_out_beat = r_s3_vld && i_out_ready;
    // The output stage frees up only once the last beat of its item is taken.
    assign w_en3      = !r_s3_vld || (i_out_ready && !r_s3_two);
    assign w_en2      = !r_s2_vld || w_en3;
    assign w_en1      = !r_s1_vld || w_en2;
    assign o_in_ready = w_en1;

    always_comb begin
        n_s1_chk.fits12 = (i_immediate_value >= rvie_pkg::IMM12_MIN) &&
                          (i_immediate_value <= rvie_pkg::IMM12_MAX);
        n_s1_chk.le63   = (i_immediate_value[31:6] == 26'd0);
        n_s1_chk.le31   = (i_immediate_value[31:5] == 27'd0);
        n_s1_chk.even   = !i_immediate_value[0];
        n_s1_chk.br_ok  = (i_immediate_value >= rvie_pkg::BR_MIN) &&
                          (i_immediate_value <= rvie_pkg::BR_MAX);
        n_s1_chk.jmp_ok = (i_immediate_value >= rvie_pkg::JMP_MIN) &&
                          (i_immediate_value <= rvie_pkg::JMP_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en1) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r_s1_act <= rvie_pkg::decode_action(i_action);
            r_s1_rd  <= i_dest_reg;
            r_s1_rs1 <= i_src1_reg;
            r_s1_rs2 <= i_src2_reg;
            r_s1_imm <= i_immediate_value;
            r_s1_chk <= n_s1_chk;
        end
    end

    // Upper part of a long li: (imm - sext(imm[11:0])) >> 12 is imm[31:12]
    // plus one when bit 11 is set.
    assign w_li_hi = r_s1_imm[31:12] + {19'd0, r_s1_imm[11]};

    always_comb begin
        n_s2_word0 = 32'd0;
        n_s2_word1 = 32'd0;
        n_s2_two   = 1'b0;
        n_s2_rej   = 1'b0;
        unique case (r_s1_act.kind)
            rvie_pkg::KIND_R: begin
                n_s2_word0 = rvie_pkg::pack_r(r_s1_act.opc, r_s1_act.f3, r_s1_act.f7,
                                              r_s1_rd, r_s1_rs1, r_s1_rs2);
            end
            rvie_pkg::KIND_I: begin
                n_s2_rej   = !r_s1_chk.fits12;
                n_s2_word0 = rvie_pkg::pack_i(r_s1_act.opc, r_s1_act.f3, r_s1_rd,
                                              r_s1_rs1, r_s1_imm[11:0]);
            end
            rvie_pkg::KIND_SH: begin
                n_s2_rej   = !r_s1_chk.le63;
                n_s2_word0 = rvie_pkg::pack_i(r_s1_act.opc, r_s1_act.f3, r_s1_rd, r_s1_rs1,
                                              {r_s1_act.f7[5:0], r_s1_imm[5:0]});
            end
            rvie_pkg::KIND_SHW: begin
                n_s2_rej   = !r_s1_chk.le31;
                n_s2_word0 = rvie_pkg::pack_r(r_s1_act.opc, r_s1_act.f3, r_s1_act.f7,
                                              r_s1_rd, r_s1_rs1, r_s1_imm[4:0]);
            end
            rvie_pkg::KIND_S: begin
                n_s2_rej   = !r_s1_chk.fits12;
                n_s2_word0 = rvie_pkg::pack_s(r_s1_act.opc, r_s1_act.f3, r_s1_rs1,
                                              r_s1_rs2, r_s1_imm[11:0]);
            end
            rvie_pkg::KIND_U: begin
                n_s2_word0 = {r_s1_imm[19:0], r_s1_rd, r_s1_act.opc};
            end
            rvie_pkg::KIND_B: begin
                n_s2_rej   = !(r_s1_chk.even && r_s1_chk.br_ok);
                n_s2_word0 = rvie_pkg::pack_b(r_s1_act.f3, r_s1_rs1, r_s1_rs2,
                                              r_s1_imm[12:0]);
            end
            rvie_pkg::KIND_BZ: begin
                n_s2_rej   = !(r_s1_chk.even && r_s1_chk.br_ok);
                n_s2_word0 = rvie_pkg::pack_b(r_s1_act.f3, r_s1_rs1, rvie_pkg::REG_ZERO,
                                              r_s1_imm[12:0]);
            end
            rvie_pkg::KIND_J: begin
                n_s2_rej   = !(r_s1_chk.even && r_s1_chk.jmp_ok);
                n_s2_word0 = rvie_pkg::pack_j(r_s1_rd, r_s1_imm[20:0]);
            end
            rvie_pkg::KIND_JZ: begin
                n_s2_rej   = !(r_s1_chk.even && r_s1_chk.jmp_ok);
                n_s2_word0 = rvie_pkg::pack_j(rvie_pkg::REG_ZERO, r_s1_imm[20:0]);
            end
            rvie_pkg::KIND_JRA: begin
                n_s2_rej   = !(r_s1_chk.even && r_s1_chk.jmp_ok);
                n_s2_word0 = rvie_pkg::pack_j(rvie_pkg::REG_RA, r_s1_imm[20:0]);
            end
            rvie_pkg::KIND_RET: begin
                n_s2_word0 = rvie_pkg::pack_i(rvie_pkg::OPC_JALR, 3'd0, rvie_pkg::REG_ZERO,
                                              rvie_pkg::REG_RA, 12'd0);
            end
            rvie_pkg::KIND_JR: begin
                n_s2_word0 = rvie_pkg::pack_i(rvie_pkg::OPC_JALR, 3'd0, rvie_pkg::REG_ZERO,
                                              r_s1_rs1, 12'd0);
            end
            rvie_pkg::KIND_NOP: begin
                n_s2_word0 = rvie_pkg::pack_i(rvie_pkg::OPC_OPIMM, 3'd0, rvie_pkg::REG_ZERO,
                                              rvie_pkg::REG_ZERO, 12'd0);
            end
            rvie_pkg::KIND_MV: begin
                n_s2_word0 = rvie_pkg::pack_i(rvie_pkg::OPC_OPIMM, 3'd0, r_s1_rd,
                                              r_s1_rs1, 12'd0);
            end
            rvie_pkg::KIND_LI: begin
                if (r_s1_chk.fits12) begin
                    n_s2_word0 = rvie_pkg::pack_i(rvie_pkg::OPC_OPIMM, 3'd0, r_s1_rd,
                                                  rvie_pkg::REG_ZERO, r_s1_imm[11:0]);
                end else begin
                    n_s2_two   = 1'b1;
                    n_s2_word0 = {w_li_hi, r_s1_rd, rvie_pkg::OPC_LUI};
                    n_s2_word1 = rvie_pkg::pack_i(rvie_pkg::OPC_OPIMM, 3'd0, r_s1_rd,
                                                  r_s1_rd, r_s1_imm[11:0]);
                end
            end
            default: begin
                n_s2_rej = 1'b1;
            end
        endcase
        if (n_s2_rej) begin
            n_s2_word0 = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_s1_vld) begin
            r_s2_word0 <= n_s2_word0;
            r_s2_word1 <= n_s2_word1;
            r_s2_two   <= n_s2_two;
            r_s2_rej   <= n_s2_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s3_two <= 1'b0;
        end else if (w_en3) begin
            r_s3_vld <= r_s2_vld;
            r_s3_two <= r_s2_vld && r_s2_two;
        end else if (w_out_beat) begin
            // The lui beat has gone; the addi beat follows from the same item.
            r_s3_two <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_s2_vld) begin
            r_s3_word  <= r_s2_word0;
            r_s3_word1 <= r_s2_word1;
            r_s3_rej   <= r_s2_rej;
        end else if (!w_en3 && w_out_beat) begin
            r_s3_word  <= r_s3_word1;
        end
    end

    assign o_out_valid        = r_s3_vld;
    assign o_instruction_word = r_s3_word;
    assign o_rejected         = r_s3_rej;
    assign o_last_word        = !r_s3_two;

endmodule

[rtl/core/rvie_port_checker.sv]
// ----------------------------------------------------------------------------
// Instruction encoder port checker
// Watches the encoder's ports and flags broken result sequences.
// ----------------------------------------------------------------------------
`include "riscv_instruction_encoder_core_assert.svh"

module rvie_port_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input logic [31:0]  o_instruction_word,
    input logic         o_rejected,
    input logic         o_last_word
);

    `RVIE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_instruction_word) && $stable(o_rejected) && $stable(o_last_word), "result beat changed while stalled")

    `RVIE_ASSERT_NOW(a_rej_single, o_out_valid && o_rejected, o_instruction_word == 32'd0 && o_last_word, "rejected beat must be a single zero word")

    `RVIE_ASSERT_NOW(a_first_is_lui, o_out_valid && !o_last_word, o_instruction_word[6:0] == rvie_pkg::OPC_LUI && !o_rejected, "non-final beat must be a lui word")

    `RVIE_ASSERT_NEXT(a_second_follows, o_out_valid && i_out_ready && !o_last_word, o_out_valid && o_last_word && !o_rejected && o_instruction_word[6:0] == rvie_pkg::OPC_OPIMM, "lui beat not followed by its addi beat")

endmodule

bind riscv_instruction_encoder_core rvie_port_checker u_rvie_port_checker (.*);
